// ----- sv/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted maximum priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_DEPTH = 16;
  localparam int VAL_W     = 32;

  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] value;
  } spq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic [1:0]              status;
  } spq_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

endpackage

// ----- sv/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value, keeps it, takes the new value
// or takes a neighbour's value on push and pop.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  spq_ctrl_t               ctrl,
  input  logic                    occupied,
  input  logic signed [VAL_W-1:0] new_value,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic                    left_stay,
  input  logic signed [VAL_W-1:0] right_data,
  output logic signed [VAL_W-1:0] data,
  output logic                    stay
);

  assign stay = occupied && (data >= new_value);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (!stay) begin
        data <= left_stay ? new_value : left_data;
      end
    end else if (ctrl.pop) begin
      data <= right_data;
    end
  end

endmodule

// ----- sv/sorted_max_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_top
// Bounded maximum priority queue: a chain of cells kept in descending order,
// largest at the head, with a registered result word.
// ----------------------------------------------------------------------------
// Each result word is registered and is valid in the cycle after acceptance.
// Throughput: one word per cycle while the result side is not stalled;
// every cell compares against the new value in parallel, shifting one place.
// Reset clears the entry count and the result valid; cell contents are left.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  spq_ctrl_t               ctrl;
  spq_out_t                result;
  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic                    cell_stay [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  assign ctrl.push = accept && (in_data.req_type == REQ_PUSH) && !is_full;
  assign ctrl.pop  = accept && (in_data.req_type == REQ_POP) && !is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic                    left_s;
    logic signed [VAL_W-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = '0;
      assign left_s = 1'b1;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign left_s = cell_stay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (count > CW'(i)),
      .new_value  (in_data.value),
      .left_data  (left_d),
      .left_stay  (left_s),
      .right_data (right_d),
      .data       (cell_data[i]),
      .stay       (cell_stay[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    if (in_data.req_type == REQ_PUSH) begin
      result.popped_value = '0;
      result.status       = is_full ? ST_FULL : ST_PUSHED;
    end else if (is_empty) begin
      result.popped_value = EMPTY_VALUE;
      result.status       = ST_EMPTY;
    end else begin
      result.popped_value = cell_data[0];
      result.status       = ST_POPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// ----- sv/spq_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_check
// Port-level checks of the sorted maximum priority queue.
// ----------------------------------------------------------------------------
module spq_check
  import spq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input spq_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output skid");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |-> out_data.popped_value == EMPTY_VALUE)
    else $error("empty pop without all-ones value");

  a_push_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_PUSHED || out_data.status == ST_FULL)
      |-> out_data.popped_value == '0)
    else $error("push result with non-zero value");

endmodule

bind sorted_max_priority_queue_top spq_check u_spq_check (.*);

// ----- tb/sv/sorted_max_priority_queue_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_top_test
// Self-checking bench for the sorted maximum priority queue. A short directed
// table covers the extreme values, both request types, pop on empty, push on
// full and equal values. About four hundred random words follow. They are
// pushed and popped in bursts, so the queue swings between empty and full.
// Every result word is checked against its table row or a behavioural copy of
// the queue, under random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_top_test;
  import spq_pkg::*;

  localparam int N_DIRECTED   = 24;
  localparam int N_PER_PHASE  = 134;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    spq_in_t  word;
    logic     fixed;
    spq_out_t result;
  } stimulus_row_t;

  localparam stimulus_row_t DIRECTED_WORDS [N_DIRECTED] = '{
    {REQ_POP,  32'sd0,          1'b1, EMPTY_VALUE,      ST_EMPTY},
    {REQ_PUSH, 32'sh7FFFFFFF,   1'b1, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sh80000000,   1'b1, 32'sd0,           ST_PUSHED},
    {REQ_POP,  32'shFFFFFFFF,   1'b1, 32'sh7FFFFFFF,    ST_POPPED},
    {REQ_POP,  32'sd0,          1'b1, 32'sh80000000,    ST_POPPED},
    {REQ_POP,  32'sh7FFFFFFF,   1'b1, EMPTY_VALUE,      ST_EMPTY},
    {REQ_PUSH, 32'sd5,          1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, -32'sd5,         1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd0,          1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd5,          1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sh7FFFFFFF,   1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sh80000000,   1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd1,          1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, -32'sd1,         1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd100,        1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd5,          1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, -32'sd100,       1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd0,          1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sh55555555,   1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'shAAAAAAAA,   1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd7,          1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, -32'sd7,         1'b0, 32'sd0,           ST_PUSHED},
    {REQ_PUSH, 32'sd1234,       1'b1, 32'sd0,           ST_FULL},
    {REQ_POP,  32'sd0,          1'b0, 32'sd0,           ST_POPPED}
  };

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  spq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spq_out_t out_data;

  logic signed [VAL_W-1:0] held_values [$];
  spq_out_t                expected_results [$];
  stimulus_row_t           offered_words [$];

  int mismatch_count = 0;
  int send_idle_pct  = 6;
  int recv_idle_pct  = 54;
  int hold_requests  = 0;

  sorted_max_priority_queue_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic spq_out_t sorted_queue_step(input spq_in_t word);
    spq_out_t res;
    int       pos;
    res = '{popped_value: 32'sd0, status: ST_PUSHED};
    if (word.req_type == REQ_PUSH) begin
      if (held_values.size() >= SPQ_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = held_values.size();
        while (pos > 0 && held_values[pos-1] > word.value) pos--;
        held_values.insert(pos, word.value);
      end
    end else if (held_values.size() == 0) begin
      res = '{popped_value: EMPTY_VALUE, status: ST_EMPTY};
    end else begin
      res = '{popped_value: held_values.pop_back(), status: ST_POPPED};
    end
    return res;
  endfunction

  function automatic spq_in_t random_word(input int push_pct);
    spq_in_t word;
    word.req_type = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
    case ($urandom_range(3))
      0: word.value = $signed($urandom_range(15)) - 32'sd8;
      1: word.value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: word.value = $signed($urandom);
    endcase
    return word;
  endfunction

  // hold the word until accepted; idle beforehand at random
  task automatic offer(input stimulus_row_t row);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    offered_words.push_back(row);
    in_valid <= 1'b1;
    in_data  <= row.word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 || offered_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    stimulus_row_t row;
    spq_out_t      predicted;
    spq_out_t      want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        row       = offered_words.pop_front();
        predicted = sorted_queue_step(row.word);
        expected_results.push_back(row.fixed ? row.result : predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none, actual %h/%0d",
                   $time, out_data.popped_value, out_data.status);
        end else begin
          want = expected_results.pop_front();
          if (out_data.popped_value !== want.popped_value) begin
            mismatch_count++;
            $display("%0t: popped_value mismatch, expected %0d, actual %0d",
                     $time, want.popped_value, out_data.popped_value);
          end
          if (out_data.status !== want.status) begin
            mismatch_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end
        end
      end
    end
  end

  initial begin
    stimulus_row_t row;
    int            push_pct;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_WORDS[i]) offer(DIRECTED_WORDS[i]);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 6 : 0;
      if (phase == 0) hold_requests++;
      push_pct = 80;
      for (int n = 0; n < N_PER_PHASE; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
          endcase
        end
        row       = '0;
        row.word  = random_word(push_pct);
        offer(row);
      end
      if (phase == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("sorted_max_priority_queue_top_test: PASS");
    end else begin
      $display("sorted_max_priority_queue_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("sorted_max_priority_queue_top_test: FAIL");
    $finish;
  end

endmodule

// ----- sorted_max_priority_queue_top.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_max_priority_queue_top.sv
sv/spq_check.sv
tb/sv/sorted_max_priority_queue_top_test.sv
